FILE: rtl/core/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// Types, constants and byte helpers shared by the ARP request responder.
// ----------------------------------------------------------------------------
package arpr_pkg;

	localparam int HDR_BYTES   = 42;
	localparam int HDR_AW      = 6;
	localparam int REPLY_BYTES = 60;
	localparam int CFG_IDX_W   = 2;

	// Header and reply offsets; the ARP layout puts both at the same places.
	localparam int OFS_SRC_MAC = 6;
	localparam int OFS_FIXED   = 12;
	localparam int OFS_SHA     = 22;
	localparam int OFS_SPA     = 28;
	localparam int OFS_THA     = 32;
	localparam int OFS_TPA     = 38;

	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_LOOKUP  = 1'b1;

	localparam logic KIND_REPLY  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = 2'd1;

	// Bytes 12..21: ethertype, hardware type, protocol type, lengths, opcode.
	localparam logic [7:0] REQ_FIXED [10] = '{
		8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
	};
	localparam logic [7:0] RPL_FIXED [10] = '{
		8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
	};

	typedef struct packed {
		logic        opcode;
		logic [7:0]  rx_byte;
		logic        rx_last;
		logic [31:0] query_ip;
	} arpr_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic        lookup_hit;
		logic [47:0] lookup_mac;
	} arpr_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [47:0]          wdata;
	} arpr_cfg_t;

	typedef struct packed {
		logic              en;
		logic [HDR_AW-1:0] addr;
		logic [7:0]        data;
	} arpr_wr_t;

	typedef struct packed {
		logic              en;
		logic [HDR_AW-1:0] addr;
	} arpr_rd_t;

	typedef struct packed {
		logic        start_reply;
		logic        lookup;
		logic        lookup_hit;
		logic [47:0] lookup_mac;
	} arpr_evt_t;

	function automatic logic hdr_byte_ok(input logic [HDR_AW-1:0] idx, input logic [7:0] b);
		logic ok;
		ok = 1'b1;
		if (idx >= HDR_AW'(OFS_FIXED) && idx < HDR_AW'(OFS_SHA))
			ok = (b == REQ_FIXED[4'(idx - HDR_AW'(OFS_FIXED))]);
		return ok;
	endfunction

	function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
		return 8'(mac >> {3'd5 - k, 3'b000});
	endfunction

	function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
		return 8'(ip >> {2'd3 - k, 3'b000});
	endfunction

	// Header address that feeds reply byte i; only bytes 0..5 and 32..41 use it.
	function automatic logic [HDR_AW-1:0] reply_hdr_addr(input logic [7:0] i);
		logic [7:0] a;
		if (i < 8'(OFS_SRC_MAC))
			a = i + 8'(OFS_SRC_MAC);
		else
			a = i - 8'(OFS_THA - OFS_SHA);
		return HDR_AW'(a);
	endfunction

	function automatic logic [7:0] reply_byte(input logic [7:0] i, input logic [7:0] hdr,
		input logic [31:0] ip, input logic [47:0] mac);
		logic [7:0] b;
		b = 8'h00;
		if (i < 8'(OFS_SRC_MAC))
			b = hdr;
		else if (i < 8'(OFS_FIXED))
			b = mac_byte(mac, 3'(i - 8'(OFS_SRC_MAC)));
		else if (i < 8'(OFS_SHA))
			b = RPL_FIXED[4'(i - 8'(OFS_FIXED))];
		else if (i < 8'(OFS_SPA))
			b = mac_byte(mac, 3'(i - 8'(OFS_SHA)));
		else if (i < 8'(OFS_THA))
			b = ip_byte(ip, 2'(i - 8'(OFS_SPA)));
		else if (i < 8'(HDR_BYTES))
			b = hdr;
		return b;
	endfunction

endpackage

FILE: rtl/core/arpr_stream_if.sv
// ----------------------------------------------------------------------------
// arpr_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface arpr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/arpr_hdr_mem.sv
// ----------------------------------------------------------------------------
// arpr_hdr_mem
// Header store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpr_hdr_mem (
	input  logic             clk,
	input  arpr_pkg::arpr_wr_t wr,
	input  arpr_pkg::arpr_rd_t rd,
	output logic [7:0]       rdata
);
	import arpr_pkg::*;

	logic [7:0] mem [HDR_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/arpr_rx_cache.sv
// ----------------------------------------------------------------------------
// arpr_rx_cache
// Byte counter, on-the-fly header checks and the one-entry address cache.
// ----------------------------------------------------------------------------
module arpr_rx_cache (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  arpr_pkg::arpr_in_t  item,
	input  logic [31:0]         local_ip,
	output arpr_pkg::arpr_wr_t  wr,
	output arpr_pkg::arpr_evt_t evt
);
	import arpr_pkg::*;

	logic [HDR_AW-1:0] cnt_q, cnt_n;
	logic              ok_q, ok_n;
	logic [31:0]       tip_q, tip_n;
	logic [47:0]       smac_q, smac_n;
	logic [31:0]       sip_q, sip_n;
	logic              cache_valid_q;
	logic [31:0]       cache_ip_q;
	logic [47:0]       cache_mac_q;
	logic              byte_fire, store, pass;

	always_comb begin
		byte_fire = fire && (item.opcode == OP_RX_BYTE);
		store     = cnt_q < HDR_AW'(HDR_BYTES);
		cnt_n     = store ? cnt_q + 1'b1 : cnt_q;
		ok_n      = ok_q & (~store | hdr_byte_ok(cnt_q, item.rx_byte));
		tip_n     = tip_q;
		smac_n    = smac_q;
		sip_n     = sip_q;
		if (store && cnt_q >= HDR_AW'(OFS_TPA))
			tip_n = {tip_q[23:0], item.rx_byte};
		if (store && cnt_q >= HDR_AW'(OFS_SHA) && cnt_q < HDR_AW'(OFS_SPA))
			smac_n = {smac_q[39:0], item.rx_byte};
		if (store && cnt_q >= HDR_AW'(OFS_SPA) && cnt_q < HDR_AW'(OFS_THA))
			sip_n = {sip_q[23:0], item.rx_byte};
		// The frame's last byte may itself be the one that completes the header.
		pass = (cnt_n == HDR_AW'(HDR_BYTES)) && ok_n && (tip_n == local_ip);

		wr.en   = byte_fire && store;
		wr.addr = cnt_q;
		wr.data = item.rx_byte;

		evt.start_reply = byte_fire && item.rx_last && pass;
		evt.lookup      = fire && (item.opcode == OP_LOOKUP);
		evt.lookup_hit  = cache_valid_q && (cache_ip_q == item.query_ip);
		evt.lookup_mac  = evt.lookup_hit ? cache_mac_q : 48'h0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			ok_q          <= 1'b1;
			cache_valid_q <= 1'b0;
			cache_ip_q    <= '0;
			cache_mac_q   <= '0;
		end else if (byte_fire) begin
			if (item.rx_last) begin
				cnt_q <= '0;
				ok_q  <= 1'b1;
			end else begin
				cnt_q <= cnt_n;
				ok_q  <= ok_n;
			end
			if (evt.start_reply) begin
				cache_valid_q <= 1'b1;
				cache_ip_q    <= sip_n;
				cache_mac_q   <= smac_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire) begin
			tip_q  <= tip_n;
			smac_q <= smac_n;
			sip_q  <= sip_n;
		end
	end
endmodule

FILE: rtl/core/arpr_tx_seq.sv
// ----------------------------------------------------------------------------
// arpr_tx_seq
// Reply sequencer: reads the header store ahead by one byte and fills the
// output register with reply bytes or lookup answers.
// ----------------------------------------------------------------------------
module arpr_tx_seq #(
	parameter int REPLY_BYTES = arpr_pkg::REPLY_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  arpr_pkg::arpr_evt_t evt,
	input  logic [31:0]         local_ip,
	input  logic [47:0]         local_mac,
	input  logic [7:0]          rdata,
	output arpr_pkg::arpr_rd_t  rd,
	input  logic                out_ready,
	output logic                out_valid,
	output arpr_pkg::arpr_out_t out_data,
	output logic                can_accept
);
	import arpr_pkg::*;

	localparam int CW = $clog2(REPLY_BYTES);
	localparam logic [CW-1:0] LAST_IDX = CW'(REPLY_BYTES - 1);

	typedef enum logic [1:0] {
		TX_IDLE = 2'b01,
		TX_SEND = 2'b10
	} tx_state_t;

	tx_state_t state_q;
	logic [CW-1:0] idx_q;
	logic          pend_q;
	logic          ov_q;
	arpr_out_t     od_q, od_n;
	logic          slot_free, load_byte, load;

	always_comb begin
		slot_free  = !ov_q || out_ready;
		can_accept = (state_q == TX_IDLE) && slot_free;
		load_byte  = (state_q == TX_SEND) && pend_q && slot_free;
		load       = load_byte || evt.lookup;

		rd.en   = 1'b0;
		rd.addr = reply_hdr_addr(8'(idx_q));
		if (state_q == TX_SEND) begin
			if (!pend_q) begin
				rd.en = 1'b1;
			end else if (slot_free && idx_q != LAST_IDX) begin
				rd.en   = 1'b1;
				rd.addr = reply_hdr_addr(8'(idx_q) + 8'd1);
			end
		end

		od_n.result_kind = KIND_REPLY;
		od_n.tx_byte     = reply_byte(8'(idx_q), rdata, local_ip, local_mac);
		od_n.tx_last     = (idx_q == LAST_IDX);
		od_n.lookup_hit  = 1'b0;
		od_n.lookup_mac  = 48'h0;
		if (evt.lookup) begin
			od_n.result_kind = KIND_LOOKUP;
			od_n.tx_byte     = 8'h00;
			od_n.tx_last     = 1'b0;
			od_n.lookup_hit  = evt.lookup_hit;
			od_n.lookup_mac  = evt.lookup_mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TX_IDLE;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				TX_IDLE: begin
					if (evt.start_reply) begin
						state_q <= TX_SEND;
						idx_q   <= '0;
						pend_q  <= 1'b0;
					end
				end
				TX_SEND: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (slot_free) begin
						if (idx_q == LAST_IDX) begin
							state_q <= TX_IDLE;
							pend_q  <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= TX_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			od_q <= od_n;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;
endmodule

FILE: rtl/core/arp_request_responder.sv
// ----------------------------------------------------------------------------
// arp_request_responder
// ARP request responder for Ethernet/IPv4 with a one-entry address cache.
// ----------------------------------------------------------------------------
// While no reply is in progress, and the output register is free or being read
// in the same cycle, the block takes one item per cycle: a frame byte or a
// cache lookup, each lookup giving one answer item. The first 42 bytes of a
// frame go into a header store memory, and the ARP checks are accumulated as
// the bytes arrive, so the verdict is ready on the last byte. A frame that
// passes starts a REPLY_BYTES-byte reply that is read back out of the header
// store. Input is held off from then until the last reply byte is loaded:
// first the header store read, then one byte per cycle while the output side
// does not stall. The configuration channel is always ready.
// ----------------------------------------------------------------------------
module arp_request_responder #(
	parameter int REPLY_BYTES = arpr_pkg::REPLY_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	arpr_stream_if.sink          req,
	arpr_stream_if.source        rsp,
	arpr_stream_if.sink          cfg
);
	import arpr_pkg::*;

	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	arpr_in_t    req_item;
	arpr_cfg_t   cfg_item;
	arpr_out_t   out_data;
	arpr_wr_t    mem_wr;
	arpr_rd_t    mem_rd;
	arpr_evt_t   evt;
	logic [7:0]  mem_rdata;
	logic        can_accept, out_valid, req_fire;

	assign req_item  = req.data;
	assign cfg_item  = cfg.data;
	assign req.ready = can_accept;
	assign req_fire  = req.valid && can_accept;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid;
	assign rsp.data  = out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= '0;
			local_mac_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_item.index)
				REG_LOCAL_IP:  local_ip_q  <= cfg_item.wdata[31:0];
				REG_LOCAL_MAC: local_mac_q <= cfg_item.wdata;
				default: ;
			endcase
		end
	end

	arpr_rx_cache u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (req_fire),
		.item     (req_item),
		.local_ip (local_ip_q),
		.wr       (mem_wr),
		.evt      (evt)
	);

	arpr_hdr_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.rd    (mem_rd),
		.rdata (mem_rdata)
	);

	arpr_tx_seq #(
		.REPLY_BYTES (REPLY_BYTES)
	) u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.local_ip   (local_ip_q),
		.local_mac  (local_mac_q),
		.rdata      (mem_rdata),
		.rd         (mem_rd),
		.out_ready  (rsp.ready),
		.out_valid  (out_valid),
		.out_data   (out_data),
		.can_accept (can_accept)
	);

`ifndef ASSERT_OFF
	// A reply that has just started keeps the input closed.
	a_reply_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		evt.start_reply |=> !req.ready)
		else $error("input accepted right after a reply started");

	// The header store is never written past its last entry.
	a_mem_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> (mem_wr.addr < HDR_AW'(HDR_BYTES)))
		else $error("header store write out of range");

	// A lookup answer carries no reply framing.
	a_lookup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && out_data.result_kind == KIND_LOOKUP) |->
		(!out_data.tx_last && out_data.tx_byte == 8'h00))
		else $error("lookup answer carries reply byte fields");

	// The header store is only read while a reply is being sent.
	a_read_only_in_reply: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd.en |-> !req.ready)
		else $error("header store read while input is open");
`endif
endmodule
